// ----- rtl/prqs_pkg.sv -----
// Shared types, codes and default sizes for the priority ready queue scheduler.
`default_nettype none
package prqs_pkg;

    // Default sizes
    localparam int READY_DEPTH_DEF = 32;
    localparam int NUM_DISKS_DEF   = 4;
    localparam int DISK_DEPTH_DEF  = 16;

    // Request modes
    localparam logic [1:0] MODE_ADMIT    = 2'd0;
    localparam logic [1:0] MODE_DISK_REQ = 2'd1;
    localparam logic [1:0] MODE_DISK_CMP = 2'd2;
    localparam logic [1:0] MODE_REMOVE   = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_DISK  = 3'd1;
    localparam logic [2:0] ST_CPU_IDLE  = 3'd2;
    localparam logic [2:0] ST_DISK_IDLE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Queue engine operations
    localparam logic OP_ADMIT  = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam int ENTRY_W = 24;

    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  prio;
    } t_entry;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] pid;
        logic [7:0]  priority_req;
        logic [2:0]  disk;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        running_valid;
        logic [15:0] running_pid;
        logic [7:0]  running_priority;
    } t_out_item;

    typedef struct packed {
        logic   go;
        logic   op;
        t_entry entry;
    } t_eng_cmd;

    typedef struct packed {
        logic   busy;
        logic   empty;
        logic   full;
        t_entry front;
    } t_eng_stat;

endpackage
`default_nettype wire

// ----- rtl/prqs_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module prqs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/prqs_engine.sv -----
// Ready queue engine: RAM-backed queue with a one-entry-per-cycle move sequencer.
`default_nettype none
module prqs_engine
    import prqs_pkg::*;
#(
    parameter int READY_DEPTH = READY_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_eng_cmd  i_cmd,
    output t_eng_stat      o_stat
);

    localparam int AW = $clog2(READY_DEPTH);
    localparam int CW = $clog2(READY_DEPTH + 1);

    localparam logic [2:0] S_IDLE        = 3'd0;
    localparam logic [2:0] S_SHIFT       = 3'd1;
    localparam logic [2:0] S_SHIFT_END   = 3'd2;
    localparam logic [2:0] S_PUT         = 3'd3;
    localparam logic [2:0] S_COMPACT     = 3'd4;
    localparam logic [2:0] S_COMPACT_END = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_j, n_j;
    logic [AW-1:0] r_src, n_src;
    logic [AW-1:0] r_pdst, n_pdst;
    logic          r_pv, n_pv;
    logic [AW-1:0] r_put, n_put;
    t_entry        r_e, n_e;
    t_entry        r_front, n_front;
    logic [15:0]   r_pid, n_pid;
    logic          r_found, n_found;
    t_entry        r_best, n_best;
    logic [AW-1:0] r_loc, n_loc;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_rdata;
    logic          keep;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] loc_m1;

    prqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (READY_DEPTH),
        .AW    (AW)
    ) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: moves one entry per cycle through the RAM read pipeline
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_j     = r_j;
        n_src   = r_src;
        n_pdst  = r_pdst;
        n_pv    = r_pv;
        n_put   = r_put;
        n_e     = r_e;
        n_front = r_front;
        n_pid   = r_pid;
        n_found = r_found;
        n_best  = r_best;
        n_loc   = r_loc;

        ram_we    = 1'b0;
        ram_waddr = r_pdst;
        ram_wdata = ram_rdata;
        ram_raddr = r_src;

        cnt_m1 = r_count - CW'(1);
        loc_m1 = '0;

        // compaction: keep non-matching entries, track first maximum
        keep = r_pv && (ram_rdata.pid != r_pid) &&
               ((r_state == S_COMPACT) || (r_state == S_COMPACT_END));
        if (keep) begin
            ram_we    = 1'b1;
            ram_waddr = r_j[AW-1:0];
            n_j       = r_j + CW'(1);
            if (!r_found || (ram_rdata.prio > r_best.prio)) begin
                n_found = 1'b1;
                n_best  = ram_rdata;
                n_loc   = r_j[AW-1:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                n_pv = 1'b0;
                if (i_cmd.go) begin
                    if (i_cmd.op == OP_ADMIT) begin
                        if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = i_cmd.entry;
                            n_front   = i_cmd.entry;
                            n_count   = CW'(1);
                        end else if (r_front.prio < i_cmd.entry.prio) begin
                            n_state = S_SHIFT;
                            n_src   = cnt_m1[AW-1:0];
                            n_e     = i_cmd.entry;
                            n_put   = '0;
                            n_count = r_count + CW'(1);
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[AW-1:0];
                            ram_wdata = i_cmd.entry;
                            n_count   = r_count + CW'(1);
                        end
                    end else if (r_count != '0) begin
                        n_state = S_COMPACT;
                        n_src   = '0;
                        n_j     = '0;
                        n_found = 1'b0;
                        n_pid   = i_cmd.entry.pid;
                    end
                end
            end
            S_SHIFT: begin
                ram_we = r_pv;
                n_pv   = 1'b1;
                n_pdst = r_src + AW'(1);
                if (r_src == '0) begin
                    n_state = S_SHIFT_END;
                end else begin
                    n_src = r_src - AW'(1);
                end
            end
            S_SHIFT_END: begin
                ram_we  = r_pv;
                n_pv    = 1'b0;
                n_state = S_PUT;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_put;
                ram_wdata = r_e;
                if (r_put == '0) begin
                    n_front = r_e;
                end
                n_state = S_IDLE;
            end
            S_COMPACT: begin
                n_pv = 1'b1;
                if ((CW'(r_src) + CW'(1)) == r_count) begin
                    n_state = S_COMPACT_END;
                end else begin
                    n_src = r_src + AW'(1);
                end
            end
            S_COMPACT_END: begin
                n_pv    = 1'b0;
                n_count = n_j;
                n_state = S_IDLE;
                if (n_found) begin
                    n_front = n_best;
                    if (n_loc != '0) begin
                        // rotate the best entry to the front
                        loc_m1  = n_loc - AW'(1);
                        n_state = S_SHIFT;
                        n_src   = loc_m1;
                        n_e     = n_best;
                        n_put   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_src   <= n_src;
        r_pdst  <= n_pdst;
        r_put   <= n_put;
        r_e     <= n_e;
        r_front <= n_front;
        r_pid   <= n_pid;
        r_found <= n_found;
        r_best  <= n_best;
        r_loc   <= n_loc;
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(READY_DEPTH));
    assign o_stat.front = r_front;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(READY_DEPTH))
        else $error("ready count above depth");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPACT) |-> (r_j <= CW'(r_src)))
        else $error("compaction write index passed read index");

    a_put_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |=> (r_state == S_IDLE))
        else $error("put did not end the operation");

    a_shift_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_END) |=> (r_state == S_PUT))
        else $error("shift end not followed by put");

endmodule
`default_nettype wire

// ----- rtl/priority_ready_queue_scheduler.sv -----
// Top level: request decode, disk FIFOs, config register and result register.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we              | i_cfg_wdata (disks_in_use)
//
// One request at a time. An error found at accept goes straight to the result;
// admit to the back writes the ready RAM at once, and disk complete first reads
// the FIFO head. Admit to the front shifts the ready RAM (one entry a cycle).
// Remove and disk request compact the ready RAM, then rotate the best entry to
// the front when it is not already at location 0.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result is held while the next request is accepted and worked on.
`default_nettype none
module priority_ready_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int READY_DEPTH = READY_DEPTH_DEF,
    parameter int NUM_DISKS   = NUM_DISKS_DEF,
    parameter int DISK_DEPTH  = DISK_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata
);

    localparam int DW   = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;
    localparam int HW   = (DISK_DEPTH > 1) ? $clog2(DISK_DEPTH) : 1;
    localparam int NW   = $clog2(DISK_DEPTH + 1);
    localparam int SW   = NW + 1;
    localparam int FD   = NUM_DISKS * DISK_DEPTH;
    localparam int FAW  = (FD > 1) ? $clog2(FD) : 1;

    localparam logic [2:0] T_IDLE      = 3'd0;
    localparam logic [2:0] T_WAIT      = 3'd1;
    localparam logic [2:0] T_PUSH_WAIT = 3'd2;
    localparam logic [2:0] T_POP       = 3'd3;
    localparam logic [2:0] T_RESULT    = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_disks;
    logic [2:0]    r_disk, n_disk;
    t_entry        r_e, n_e;
    logic [2:0]    r_status, n_status;
    logic [HW-1:0] r_heads  [NUM_DISKS];
    logic [NW-1:0] r_counts [NUM_DISKS];
    logic [HW-1:0] n_head;
    logic [NW-1:0] n_cnt;
    logic          head_we;
    t_out_item     r_out;
    logic          r_out_v;

    t_eng_cmd      eng_cmd;
    t_eng_stat     eng_stat;

    logic [2:0]    sel_disk;
    logic [DW-1:0] sel_idx;
    logic          disk_ok;
    logic [HW-1:0] cur_head;
    logic [NW-1:0] cur_cnt;
    logic [SW-1:0] slot_sum;
    logic [SW-1:0] slot_wrap;
    logic [HW-1:0] slot;
    logic          in_acc;
    logic          out_load;

    logic           dram_we;
    logic [FAW-1:0] dram_waddr;
    logic [FAW-1:0] dram_raddr;
    t_entry         dram_rdata;

    prqs_engine #(
        .READY_DEPTH (READY_DEPTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (eng_cmd),
        .o_stat  (eng_stat)
    );

    prqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FD),
        .AW    (FAW)
    ) u_disk_ram (
        .i_clk   (i_clk),
        .i_we    (dram_we),
        .i_waddr (dram_waddr),
        .i_wdata (r_e),
        .i_raddr (dram_raddr),
        .o_rdata (dram_rdata)
    );

    // Disk selection and FIFO addressing
    assign sel_disk = (r_state == T_IDLE) ? i_in_data.disk : r_disk;
    assign sel_idx  = sel_disk[DW-1:0];
    assign disk_ok  = ({1'b0, sel_disk} < {1'b0, r_disks}) &&
                      ({1'b0, sel_disk} < 4'(NUM_DISKS));
    assign cur_head = disk_ok ? r_heads[sel_idx] : '0;
    assign cur_cnt  = disk_ok ? r_counts[sel_idx] : '0;

    assign slot_sum  = SW'(cur_head) + SW'(cur_cnt);
    assign slot_wrap = (slot_sum >= SW'(DISK_DEPTH)) ? (slot_sum - SW'(DISK_DEPTH)) : slot_sum;
    assign slot      = slot_wrap[HW-1:0];

    assign dram_raddr = FAW'(int'(sel_idx) * DISK_DEPTH + int'(cur_head));
    assign dram_waddr = FAW'(int'(sel_idx) * DISK_DEPTH + int'(slot));

    assign in_acc   = i_in_valid && (r_state == T_IDLE);
    assign out_load = (r_state == T_RESULT) && (!r_out_v || !i_out_stall);

    // Request sequencer
    always_comb begin
        n_state  = r_state;
        n_disk   = r_disk;
        n_e      = r_e;
        n_status = r_status;
        eng_cmd  = '0;
        dram_we  = 1'b0;
        head_we  = 1'b0;
        n_head   = cur_head;
        n_cnt    = cur_cnt;

        unique case (r_state)
            T_IDLE: begin
                if (in_acc) begin
                    n_disk   = i_in_data.disk;
                    n_status = ST_OK;
                    unique case (i_in_data.mode)
                        MODE_ADMIT: begin
                            if (eng_stat.full) begin
                                n_status = ST_FULL;
                                n_state  = T_RESULT;
                            end else begin
                                eng_cmd.go    = 1'b1;
                                eng_cmd.op    = OP_ADMIT;
                                eng_cmd.entry = '{pid: i_in_data.pid,
                                                  prio: i_in_data.priority_req};
                                n_state       = T_WAIT;
                            end
                        end
                        MODE_REMOVE: begin
                            eng_cmd.go        = 1'b1;
                            eng_cmd.op        = OP_REMOVE;
                            eng_cmd.entry.pid = i_in_data.pid;
                            n_state           = T_WAIT;
                        end
                        MODE_DISK_REQ: begin
                            if (!disk_ok) begin
                                n_status = ST_BAD_DISK;
                                n_state  = T_RESULT;
                            end else if (eng_stat.empty) begin
                                n_status = ST_CPU_IDLE;
                                n_state  = T_RESULT;
                            end else begin
                                n_e               = eng_stat.front;
                                eng_cmd.go        = 1'b1;
                                eng_cmd.op        = OP_REMOVE;
                                eng_cmd.entry.pid = eng_stat.front.pid;
                                n_state           = T_PUSH_WAIT;
                            end
                        end
                        MODE_DISK_CMP: begin
                            if (!disk_ok) begin
                                n_status = ST_BAD_DISK;
                                n_state  = T_RESULT;
                            end else if (cur_cnt == '0) begin
                                n_status = ST_DISK_IDLE;
                                n_state  = T_RESULT;
                            end else begin
                                // head read issued now, data next cycle
                                head_we = 1'b1;
                                n_head  = ((HW+1)'(cur_head) + (HW+1)'(1) ==
                                           (HW+1)'(DISK_DEPTH)) ? '0 : cur_head + HW'(1);
                                n_cnt   = cur_cnt - NW'(1);
                                n_state = T_POP;
                            end
                        end
                        default: begin
                            n_state = T_RESULT;
                        end
                    endcase
                end
            end
            T_PUSH_WAIT: begin
                if (!eng_stat.busy) begin
                    if (cur_cnt == NW'(DISK_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        dram_we = 1'b1;
                        head_we = 1'b1;
                        n_cnt   = cur_cnt + NW'(1);
                    end
                    n_state = T_RESULT;
                end
            end
            T_POP: begin
                if (eng_stat.full) begin
                    n_status = ST_FULL;
                    n_state  = T_RESULT;
                end else begin
                    eng_cmd.go    = 1'b1;
                    eng_cmd.op    = OP_ADMIT;
                    eng_cmd.entry = dram_rdata;
                    n_state       = T_WAIT;
                end
            end
            T_WAIT: begin
                if (!eng_stat.busy) begin
                    n_state = T_RESULT;
                end
            end
            T_RESULT: begin
                if (out_load) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_disks <= 3'd4;
            r_out_v <= 1'b0;
            for (int k = 0; k < NUM_DISKS; k++) begin
                r_heads[k]  <= '0;
                r_counts[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_disks <= i_cfg_wdata;
            end
            if (head_we) begin
                r_heads[sel_idx]  <= n_head;
                r_counts[sel_idx] <= n_cnt;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_disk   <= n_disk;
        r_e      <= n_e;
        r_status <= n_status;
        if (out_load) begin
            r_out.status           <= r_status;
            r_out.running_valid    <= !eng_stat.empty;
            r_out.running_pid      <= eng_stat.empty ? 16'd0 : eng_stat.front.pid;
            r_out.running_priority <= eng_stat.empty ? 8'd0 : eng_stat.front.prio;
        end
    end

    assign o_in_stall  = (r_state != T_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Checks
    a_disk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_we |-> (n_cnt <= NW'(DISK_DEPTH)))
        else $error("disk FIFO count above depth");

    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.running_valid) |->
            ((r_out.running_pid == 16'd0) && (r_out.running_priority == 8'd0)))
        else $error("idle result carries a pid");

    a_pop_admits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_POP) |-> !eng_stat.busy)
        else $error("pop while engine busy");

    a_engine_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_cmd.go |-> !eng_stat.busy)
        else $error("engine started while busy");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the priority ready queue scheduler: directed table, random requests, predictor.
`timescale 1ns / 1ps
module tb_top;
    import prqs_pkg::*;

    localparam int RQ_DEPTH = 32;
    localparam int N_DISKS  = 4;
    localparam int DQ_DEPTH = 16;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1650;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic      i_cfg_we;
    logic [2:0] i_cfg_wdata;

    priority_ready_queue_scheduler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // Predictor state
    t_entry     rq[RQ_DEPTH];
    int         rq_cnt;
    t_entry     dq[N_DISKS][DQ_DEPTH];
    int         dq_head[N_DISKS];
    int         dq_cnt[N_DISKS];
    logic [2:0] disks_cfg;

    t_out_item  expected_q[$];
    int         mismatches;
    int         idle_cycles;
    bit         timed_out;
    bit         hold_off;
    bit         sender_done;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit rq_push(t_entry e);
        if (rq_cnt >= RQ_DEPTH) return 1'b0;
        if (rq_cnt == 0 || rq[0].prio < e.prio) begin
            for (int i = rq_cnt; i > 0; i--) rq[i] = rq[i-1];
            rq[0] = e;
        end else begin
            rq[rq_cnt] = e;
        end
        rq_cnt++;
        return 1'b1;
    endfunction

    function automatic void rq_purge(logic [15:0] pid);
        int j;
        int loc;
        t_entry e;
        j = 0;
        loc = 0;
        for (int i = 0; i < rq_cnt; i++)
            if (rq[i].pid != pid) begin
                rq[j] = rq[i];
                j++;
            end
        rq_cnt = j;
        if (rq_cnt == 0) return;
        for (int i = 1; i < rq_cnt; i++)
            if (rq[i].prio > rq[loc].prio) loc = i;
        e = rq[loc];
        for (int i = loc; i > 0; i--) rq[i] = rq[i-1];
        rq[0] = e;
    endfunction

    // Apply one request to the model and return the resulting schedule view
    function automatic t_out_item schedule_step(t_in_item r);
        t_out_item o;
        t_entry e;
        int ndisk;
        int d;
        o = '0;
        o.status = ST_OK;
        ndisk = (disks_cfg < N_DISKS) ? disks_cfg : N_DISKS;
        d = r.disk;
        if (r.mode == MODE_ADMIT) begin
            e.pid = r.pid;
            e.prio = r.priority_req;
            if (!rq_push(e)) o.status = ST_FULL;
        end else if (r.mode == MODE_REMOVE) begin
            rq_purge(r.pid);
        end else if (d >= ndisk) begin
            o.status = ST_BAD_DISK;
        end else if (r.mode == MODE_DISK_REQ) begin
            if (rq_cnt == 0) begin
                o.status = ST_CPU_IDLE;
            end else begin
                e = rq[0];
                rq_purge(e.pid);
                if (dq_cnt[d] >= DQ_DEPTH) o.status = ST_FULL;
                else begin
                    dq[d][(dq_head[d] + dq_cnt[d]) % DQ_DEPTH] = e;
                    dq_cnt[d]++;
                end
            end
        end else begin
            if (dq_cnt[d] == 0) begin
                o.status = ST_DISK_IDLE;
            end else begin
                e = dq[d][dq_head[d]];
                dq_head[d] = (dq_head[d] + 1) % DQ_DEPTH;
                dq_cnt[d]--;
                if (!rq_push(e)) o.status = ST_FULL;
            end
        end
        if (rq_cnt > 0) begin
            o.running_valid = 1'b1;
            o.running_pid = rq[0].pid;
            o.running_priority = rq[0].prio;
        end
        return o;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_request(t_in_item r, bit has_typed, t_out_item typed);
        t_out_item p;
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        p = schedule_step(r);
        if (has_typed && p != typed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with predictor: row %h pred %h", typed, p);
        end
        expected_q.insert(expected_q.size(), p);
    endtask

    task automatic write_disks(logic [2:0] v);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        disks_cfg = v;
    endtask

    function automatic t_in_item mk(logic [1:0] m, logic [15:0] pid, logic [7:0] pr,
                                    logic [2:0] d);
        t_in_item r;
        r.mode = m;
        r.pid = pid;
        r.priority_req = pr;
        r.disk = d;
        return r;
    endfunction

    function automatic t_out_item res(logic [2:0] s, logic v, logic [15:0] pid,
                                      logic [7:0] pr);
        t_out_item o;
        o.status = s;
        o.running_valid = v;
        o.running_pid = pid;
        o.running_priority = pr;
        return o;
    endfunction

    // Result checker and receiver stall
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                exp_item = expected_q[0];
                expected_q.delete(0);
                if (o_out_data !== exp_item) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected st=%0d v=%0d pid=%h pr=%h, got st=%0d v=%0d pid=%h pr=%h",
                            exp_item.status, exp_item.running_valid, exp_item.running_pid,
                            exp_item.running_priority, o_out_data.status,
                            o_out_data.running_valid, o_out_data.running_pid,
                            o_out_data.running_priority);
                end
            end
        end
        if (hold_off) i_out_stall <= 1'b1;
        else if ($urandom_range(0, 29) == 0) i_out_stall <= 1'b1;
        else if (i_out_stall && $urandom_range(0, 2) != 0) i_out_stall <= 1'b1;
        else i_out_stall <= 1'b0;
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        hold_off = 1'b0;
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Watchdog on cycles without any transfer
    initial begin
        timed_out = 1'b0;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
                idle_cycles = 0;
            else if (!(sender_done && expected_q.size() == 0))
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_in_item  rows_in[$];
        t_out_item rows_out[$];
        bit        rows_typed[$];
        t_in_item  r;
        int        pool[$];
        int        k;
        logic [2:0] cfgs[5];
        mismatches = 0;
        sender_done = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        rq_cnt = 0;
        disks_cfg = 3'd4;
        for (int i = 0; i < N_DISKS; i++) begin
            dq_head[i] = 0;
            dq_cnt[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: after reset errors, extremes, duplicates, absent pid
        rows_in = '{mk(MODE_DISK_REQ, 16'h0, 8'h0, 3'd0), mk(MODE_DISK_CMP, 16'h0, 8'h0, 3'd3),
                    mk(MODE_DISK_REQ, 16'h0, 8'h0, 3'd7), mk(MODE_REMOVE, 16'h1234, 8'h0, 3'd0),
                    mk(MODE_ADMIT, 16'hFFFF, 8'h00, 3'd0), mk(MODE_ADMIT, 16'h0000, 8'hFF, 3'd0),
                    mk(MODE_ADMIT, 16'h0005, 8'hFF, 3'd0), mk(MODE_ADMIT, 16'h0005, 8'h80, 3'd0),
                    mk(MODE_DISK_REQ, 16'h0, 8'h0, 3'd3), mk(MODE_DISK_CMP, 16'h0, 8'h0, 3'd3),
                    mk(MODE_REMOVE, 16'h0005, 8'h0, 3'd0), mk(MODE_REMOVE, 16'hAAAA, 8'h0, 3'd0),
                    mk(MODE_DISK_REQ, 16'h0, 8'h0, 3'd0), mk(MODE_DISK_CMP, 16'h0, 8'h0, 3'd4),
                    mk(MODE_DISK_CMP, 16'h0, 8'h0, 3'd2)};
        rows_out = '{res(ST_CPU_IDLE, 1'b0, 16'h0, 8'h0), res(ST_DISK_IDLE, 1'b0, 16'h0, 8'h0),
                     res(ST_BAD_DISK, 1'b0, 16'h0, 8'h0), res(ST_OK, 1'b0, 16'h0, 8'h0),
                     res(ST_OK, 1'b1, 16'hFFFF, 8'h00), res(ST_OK, 1'b1, 16'h0000, 8'hFF),
                     '0, '0, '0, '0, '0, '0, '0,
                     res(ST_BAD_DISK, 1'b1, 16'hFFFF, 8'h00),
                     res(ST_DISK_IDLE, 1'b1, 16'hFFFF, 8'h00)};
        rows_typed = '{1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        foreach (rows_in[i]) send_request(rows_in[i], rows_typed[i], rows_out[i]);
        // Fill the ready queue past full
        for (int i = 0; i < RQ_DEPTH + 2; i++)
            send_request(mk(MODE_ADMIT, 16'(i), 8'(i * 7), 3'd0), 0, '0);

        cfgs = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2};
        for (int ph = 0; ph < 5; ph++) begin
            write_disks(cfgs[ph]);
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                k = $urandom_range(0, 99);
                r.disk = (k < 90) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(0, 7));
                r.priority_req = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255)
                                                             : 8'($urandom);
                // Small pid pool gives duplicates and hits on remove
                if ($urandom_range(0, 9) == 0 || pool.size() == 0) r.pid = 16'($urandom);
                else r.pid = 16'(pool[$urandom_range(0, pool.size() - 1)]);
                k = $urandom_range(0, 99);
                if (k < 40) r.mode = MODE_ADMIT;
                else if (k < 65) r.mode = MODE_DISK_REQ;
                else if (k < 88) r.mode = MODE_DISK_CMP;
                else r.mode = MODE_REMOVE;
                if (r.mode == MODE_ADMIT) begin
                    pool.insert(pool.size(), int'(r.pid));
                    if (pool.size() > 40) pool.delete(0);
                end
                send_request(r, 0, '0);
            end
        end
        i_in_valid <= 1'b0;
        sender_done = 1'b1;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end
endmodule
